[src/cwq_pkg.sv]
package cwq_pkg;

	localparam int ENTRY_SLOTS_DEF  = 32;
	localparam int FRAME_BUDGET_DEF = 16;

	localparam int ACTION_W = 3;
	localparam int REG_W    = 5;
	localparam int VALUE_W  = 8;
	localparam int CLASS_W  = 2;
	localparam int SLOT_W   = 5;
	localparam int DEPTH_W  = 6;
	localparam int DROP_W   = 32;

	localparam logic [ACTION_W-1:0] ACT_ENQUEUE     = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE      = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_MUSIC_CLEAR = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_FLUSH       = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DRAIN       = 3'd4;

	localparam logic [CLASS_W-1:0] CLASS_STEAL  = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_NOTE   = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_TIMBRE = 2'd3;

	// voice register blocks: reg_addr[4:2] of registers 4..7 and 12..15
	localparam logic [2:0] VOICE_BLK_LO = 3'd1;
	localparam logic [2:0] VOICE_BLK_HI = 3'd3;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [REG_W-1:0]    reg_addr;
		logic [VALUE_W-1:0]  reg_value;
		logic [CLASS_W-1:0]  prio_class;
		logic                voice_channel;
		logic [SLOT_W-1:0]   free_slots;
	} req_t;

	typedef struct packed {
		logic                write_valid;
		logic [REG_W-1:0]    out_reg;
		logic [VALUE_W-1:0]  out_value;
		logic                last;
		logic [DEPTH_W-1:0]  depth_now;
		logic [DROP_W-1:0]   drop_total;
	} rsp_t;

	typedef struct packed {
		logic [REG_W-1:0]   reg_addr;
		logic [VALUE_W-1:0] reg_value;
		logic [CLASS_W-1:0] prio_class;
	} entry_t;

	typedef enum logic [1:0] {
		PURGE_CHANNEL,
		PURGE_MUSIC,
		PURGE_TAKEN
	} purge_mode_t;

	typedef struct packed {
		logic               load;
		logic               scan;
		logic               compact;
		logic               start;
		logic               commit;
		logic               resp;
		logic [CLASS_W-1:0] cls;
		purge_mode_t        mode;
	} cmd_t;

	typedef struct packed {
		logic walk_done;
		logic all_taken;
		logic none;
		logic out_free;
	} sts_t;

endpackage

[src/cwq_ram.sv]
module cwq_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/cwq_ctrl.sv]
module cwq_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	input  logic [cwq_pkg::ACTION_W-1:0]    req_action,
	input  cwq_pkg::sts_t                   sts,
	output logic                            req_ready,
	output cwq_pkg::cmd_t                   cmd
);
	import cwq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMPACT,
		S_RESP
	} state_t;

	state_t             state_q, state_d;
	logic [CLASS_W-1:0] cls_q, cls_d;
	purge_mode_t        mode_q, mode_d;

	always_comb begin
		state_d     = state_q;
		cls_d       = cls_q;
		mode_d      = mode_q;
		cmd         = '0;
		cmd.cls     = cls_q;
		cmd.mode    = mode_q;
		req_ready   = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					unique case (req_action)
						ACT_REMOVE: begin
							mode_d  = PURGE_CHANNEL;
							state_d = S_COMPACT;
						end
						ACT_MUSIC_CLEAR: begin
							mode_d  = PURGE_MUSIC;
							state_d = S_COMPACT;
						end
						ACT_DRAIN: begin
							mode_d  = PURGE_TAKEN;
							cls_d   = CLASS_STEAL;
							state_d = S_SCAN;
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.none) begin
					state_d = S_RESP;
				end else if (sts.all_taken || sts.walk_done) begin
					cmd.start = 1'b1;
					if (sts.all_taken || cls_q == CLASS_TIMBRE) begin
						state_d = S_COMPACT;
					end else begin
						cls_d = cls_q + CLASS_W'(1);
					end
				end
			end
			S_COMPACT: begin
				cmd.compact = 1'b1;
				if (sts.walk_done) begin
					cmd.commit = 1'b1;
					state_d    = (mode_q == PURGE_TAKEN) ? S_IDLE : S_RESP;
				end
			end
			S_RESP: begin
				cmd.resp = 1'b1;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cls_q   <= CLASS_STEAL;
			mode_q  <= PURGE_TAKEN;
		end else begin
			state_q <= state_d;
			cls_q   <= cls_d;
			mode_q  <= mode_d;
		end
	end

endmodule

[src/cwq_dp.sv]
module cwq_dp #(
	parameter int ENTRY_SLOTS  = cwq_pkg::ENTRY_SLOTS_DEF,
	parameter int FRAME_BUDGET = cwq_pkg::FRAME_BUDGET_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cwq_pkg::req_t req,
	input  cwq_pkg::cmd_t cmd,
	output cwq_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cwq_pkg::rsp_t rsp
);
	import cwq_pkg::*;

	localparam int AW  = $clog2(ENTRY_SLOTS);
	localparam int CW  = $clog2(ENTRY_SLOTS + 1);
	localparam int LW  = $clog2(FRAME_BUDGET + 1);
	localparam int TW0 = (CW > LW) ? CW : LW;
	localparam int TW  = (TW0 > SLOT_W) ? TW0 : SLOT_W;
	localparam int EW  = $bits(entry_t);

	logic [CW-1:0]          count_q;
	logic [DROP_W-1:0]      drop_q;
	logic [ENTRY_SLOTS-1:0] taken_q;
	logic [CW-1:0]          rd_idx_q;
	logic [CW-1:0]          wr_idx_q;
	logic [LW-1:0]          n_q;
	logic                   vld_s1;
	logic [AW-1:0]          idx_s1;
	req_t                   item_q;
	logic [LW-1:0]          total_q;
	logic                   out_valid_q;
	rsp_t                   out_q;

	logic [EW-1:0] rd_data;
	entry_t        rd_entry;
	entry_t        wr_entry;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_re;

	logic [TW-1:0] lim;
	logic [TW-1:0] total_w;
	logic          enq_ok;
	logic          out_free;
	logic          issue;
	logic          hit;
	logic          stall;
	logic          adv;
	logic          del;
	logic          keep;
	logic          emit_scan;
	logic          emit_resp;

	assign rd_entry = rd_data;

	always_comb begin
		lim     = (TW'(req.free_slots) > TW'(FRAME_BUDGET)) ? TW'(FRAME_BUDGET)
		                                                    : TW'(req.free_slots);
		total_w = (lim < TW'(count_q)) ? lim : TW'(count_q);
	end

	assign enq_ok    = count_q < CW'(ENTRY_SLOTS);
	assign out_free  = !out_valid_q || rsp_ready;
	assign issue     = (cmd.scan || cmd.compact) && (rd_idx_q < count_q);
	assign hit       = vld_s1 && (rd_entry.prio_class == cmd.cls) && (n_q < total_q);
	assign stall     = cmd.scan && hit && !out_free;
	assign adv       = !stall;
	assign emit_scan = cmd.scan && hit && out_free;
	assign emit_resp = cmd.resp && out_free;

	always_comb begin
		unique case (cmd.mode)
			PURGE_CHANNEL: del = rd_entry.reg_addr[REG_W-1:2] ==
			                     (item_q.voice_channel ? VOICE_BLK_HI : VOICE_BLK_LO);
			PURGE_MUSIC:   del = rd_entry.prio_class >= CLASS_NOTE;
			PURGE_TAKEN:   del = taken_q[idx_s1];
			default:       del = 1'b0;
		endcase
	end

	assign keep = cmd.compact && vld_s1 && !del;

	always_comb begin
		if (cmd.load) begin
			ram_we              = (req.action == ACT_ENQUEUE) && enq_ok;
			ram_waddr           = count_q[AW-1:0];
			wr_entry.reg_addr   = req.reg_addr;
			wr_entry.reg_value  = req.reg_value;
			wr_entry.prio_class = req.prio_class;
		end else begin
			ram_we    = keep;
			ram_waddr = wr_idx_q[AW-1:0];
			wr_entry  = rd_entry;
		end
	end

	assign ram_re = adv && issue;

	cwq_ram #(
		.WIDTH (EW),
		.DEPTH (ENTRY_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			drop_q      <= '0;
			taken_q     <= '0;
			rd_idx_q    <= '0;
			wr_idx_q    <= '0;
			n_q         <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				taken_q  <= '0;
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				n_q      <= '0;
				vld_s1   <= 1'b0;
				if (req.action == ACT_ENQUEUE) begin
					if (enq_ok) begin
						count_q <= count_q + CW'(1);
					end else begin
						drop_q <= drop_q + DROP_W'(1);
					end
				end else if (req.action == ACT_FLUSH) begin
					count_q <= '0;
				end
			end else if (cmd.start) begin
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				vld_s1   <= 1'b0;
			end else begin
				if (adv) begin
					vld_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
				end
				if (emit_scan) begin
					taken_q[idx_s1] <= 1'b1;
					n_q             <= n_q + LW'(1);
				end
				if (keep) begin
					wr_idx_q <= wr_idx_q + CW'(1);
				end
				if (cmd.commit) begin
					count_q <= wr_idx_q;
				end
			end
			if (emit_scan || emit_resp) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q  <= req;
			total_q <= LW'(total_w);
		end
		if (adv) begin
			idx_s1 <= rd_idx_q[AW-1:0];
		end
		if (emit_scan) begin
			out_q.write_valid <= 1'b1;
			out_q.out_reg     <= rd_entry.reg_addr;
			out_q.out_value   <= rd_entry.reg_value;
			out_q.last        <= (n_q + LW'(1)) == total_q;
			out_q.depth_now   <= DEPTH_W'(count_q - CW'(total_q));
			out_q.drop_total  <= drop_q;
		end else if (emit_resp) begin
			out_q.write_valid <= 1'b0;
			out_q.out_reg     <= '0;
			out_q.out_value   <= '0;
			out_q.last        <= 1'b1;
			out_q.depth_now   <= DEPTH_W'(count_q);
			out_q.drop_total  <= drop_q;
		end
	end

	assign sts.walk_done = !vld_s1 && (rd_idx_q >= count_q);
	assign sts.all_taken = n_q == total_q;
	assign sts.none      = total_q == '0;
	assign sts.out_free  = out_free;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

[src/class_ordered_write_queue_unit.sv]
// channel  dir  handshake              payload
// req      in   req_valid / req_ready  req_t: action, write, class, voice, free slots
// rsp      out  rsp_valid / rsp_ready  rsp_t: drained write, last, depth, drop count
//
// Enqueue, flush and unknown actions do not walk the queue. Remove channel and music clear
// walk the queue once. A drain walks the entry memory up to once per class, stopping
// early once its budget is filled, and once more to compact unless its budget is zero;
// a stalled rsp holds the walk.
// Reset clears the count, drop total, walk state and output valid; the entry memory needs no clearing.
module class_ordered_write_queue_unit #(
	parameter int ENTRY_SLOTS  = cwq_pkg::ENTRY_SLOTS_DEF,
	parameter int FRAME_BUDGET = cwq_pkg::FRAME_BUDGET_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cwq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cwq_pkg::rsp_t rsp
);
	import cwq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cwq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req.action),
		.sts        (sts),
		.req_ready  (req_ready),
		.cmd        (cmd)
	);

	cwq_dp #(
		.ENTRY_SLOTS  (ENTRY_SLOTS),
		.FRAME_BUDGET (FRAME_BUDGET)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[verif/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cwq_pkg::*;

	localparam int ENTRY_SLOTS  = ENTRY_SLOTS_DEF;
	localparam int FRAME_BUDGET = FRAME_BUDGET_DEF;

	localparam logic [CLASS_W-1:0] CLASS_EFFECT = 2'd1;

	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 200;
	localparam int PRINT_LIMIT  = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	entry_t queued_writes[$];
	logic [DROP_W-1:0] dropped_writes = '0;
	rsp_t due_results[$];

	int unsigned mismatch_count = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_idle_pct = 0;
	int unsigned hold_asked = 0;
	int unsigned hold_taken = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;

	class_ordered_write_queue_unit #(
		.ENTRY_SLOTS(ENTRY_SLOTS),
		.FRAME_BUDGET(FRAME_BUDGET)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_LIMIT) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
		mismatch_count++;
	endtask

	function automatic void predict_action(input req_t item);
		entry_t kept[$];
		entry_t drained[$];
		bit taken [0:ENTRY_SLOTS-1];
		int unsigned budget;
		logic [2:0] blk;
		rsp_t res;
		taken = '{default: 1'b0};
		case (item.action)
			ACT_ENQUEUE: begin
				if (queued_writes.size() >= ENTRY_SLOTS) begin
					dropped_writes++;
				end else begin
					queued_writes.push_back('{item.reg_addr, item.reg_value, item.prio_class});
				end
			end
			ACT_REMOVE: begin
				blk = item.voice_channel ? VOICE_BLK_HI : VOICE_BLK_LO;
				foreach (queued_writes[i]) begin
					if (queued_writes[i].reg_addr[4:2] != blk) begin
						kept.push_back(queued_writes[i]);
					end
				end
				queued_writes = kept;
			end
			ACT_MUSIC_CLEAR: begin
				foreach (queued_writes[i]) begin
					if (queued_writes[i].prio_class < CLASS_NOTE) begin
						kept.push_back(queued_writes[i]);
					end
				end
				queued_writes = kept;
			end
			ACT_FLUSH: begin
				queued_writes.delete();
			end
			ACT_DRAIN: begin
				budget = (item.free_slots > FRAME_BUDGET) ? FRAME_BUDGET : item.free_slots;
				for (int c = CLASS_STEAL; c <= CLASS_TIMBRE; c++) begin
					foreach (queued_writes[i]) begin
						if (int'(queued_writes[i].prio_class) == c && drained.size() < budget) begin
							taken[i] = 1'b1;
							drained.push_back(queued_writes[i]);
						end
					end
				end
				foreach (queued_writes[i]) begin
					if (!taken[i]) begin
						kept.push_back(queued_writes[i]);
					end
				end
				queued_writes = kept;
			end
			default: begin
			end
		endcase
		res = '0;
		res.depth_now = DEPTH_W'(queued_writes.size());
		res.drop_total = dropped_writes;
		if (drained.size() == 0) begin
			res.last = 1'b1;
			due_results.push_back(res);
		end else begin
			foreach (drained[k]) begin
				res.write_valid = 1'b1;
				res.out_reg = drained[k].reg_addr;
				res.out_value = drained[k].reg_value;
				res.last = (k == drained.size() - 1);
				due_results.push_back(res);
			end
		end
	endfunction

	task automatic check_result(input rsp_t got);
		rsp_t want;
		if (due_results.size() == 0) begin
			report_mismatch($sformatf("unexpected transaction %p", got));
			return;
		end
		want = due_results.pop_front();
		if (got.write_valid !== want.write_valid)
			report_mismatch($sformatf("write_valid %b, want %b", got.write_valid, want.write_valid));
		if (got.out_reg !== want.out_reg)
			report_mismatch($sformatf("out_reg %0d, want %0d", got.out_reg, want.out_reg));
		if (got.out_value !== want.out_value)
			report_mismatch($sformatf("out_value %0h, want %0h", got.out_value, want.out_value));
		if (got.last !== want.last)
			report_mismatch($sformatf("last %b, want %b", got.last, want.last));
		if (got.depth_now !== want.depth_now)
			report_mismatch($sformatf("depth_now %0d, want %0d", got.depth_now, want.depth_now));
		if (got.drop_total !== want.drop_total)
			report_mismatch($sformatf("drop_total %0d, want %0d", got.drop_total, want.drop_total));
	endtask

	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && rsp_ready) begin
			check_result(rsp);
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (hold_asked != hold_taken) begin
			hold_taken = hold_asked;
			hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_item(input req_t item);
		if ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_ready !== 1'b1);
		predict_action(item);
	endtask

	task automatic wait_all_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
	endtask

	function automatic req_t noisy_item(input logic [ACTION_W-1:0] action);
		req_t item;
		item.action = action;
		item.reg_addr = REG_W'($urandom_range(31));
		item.reg_value = VALUE_W'($urandom_range(255));
		item.prio_class = CLASS_W'($urandom_range(3));
		item.voice_channel = 1'($urandom_range(1));
		item.free_slots = SLOT_W'($urandom_range(31));
		return item;
	endfunction

	function automatic req_t write_item(input logic [REG_W-1:0] addr,
			input logic [VALUE_W-1:0] value, input logic [CLASS_W-1:0] cls);
		req_t item;
		item = noisy_item(ACT_ENQUEUE);
		item.reg_addr = addr;
		item.reg_value = value;
		item.prio_class = cls;
		return item;
	endfunction

	function automatic req_t drain_item(input logic [SLOT_W-1:0] slots);
		req_t item;
		item = noisy_item(ACT_DRAIN);
		item.free_slots = slots;
		return item;
	endfunction

	function automatic req_t random_write();
		req_t item;
		item = noisy_item(ACT_ENQUEUE);
		if ($urandom_range(1)) begin
			item.reg_addr = {($urandom_range(1) ? VOICE_BLK_HI : VOICE_BLK_LO),
				2'($urandom_range(3))};
		end
		return item;
	endfunction

	function automatic req_t random_drain();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return drain_item('0);
		else if (roll < 30)
			return drain_item(SLOT_W'($urandom_range(31, FRAME_BUDGET + 1)));
		return drain_item(SLOT_W'($urandom_range(FRAME_BUDGET, 1)));
	endfunction

	task automatic test_directed_cases();
		send_item(drain_item(SLOT_W'(4)));
		send_item(write_item('0, '0, CLASS_TIMBRE));
		send_item(write_item('1, '1, CLASS_STEAL));
		send_item(write_item({VOICE_BLK_LO, 2'd1}, 8'hA5, CLASS_NOTE));
		send_item(write_item({VOICE_BLK_HI, 2'd1}, 8'h5A, CLASS_EFFECT));
		send_item(write_item({VOICE_BLK_LO, 2'd3}, 8'h3C, CLASS_NOTE));
		send_item(write_item(REG_W'(24), 8'hC3, CLASS_EFFECT));
		send_item(drain_item('0));
		send_item(drain_item(SLOT_W'(2)));
		send_item(noisy_item(ACT_REMOVE));
		begin
			req_t item;
			item = noisy_item(ACT_REMOVE);
			item.voice_channel = 1'b0;
			send_item(item);
			item = noisy_item(ACT_REMOVE);
			item.voice_channel = 1'b1;
			send_item(item);
		end
		send_item(write_item({VOICE_BLK_HI, 2'd2}, 8'h11, CLASS_TIMBRE));
		send_item(write_item({VOICE_BLK_LO, 2'd0}, 8'h22, CLASS_STEAL));
		send_item(noisy_item(ACT_MUSIC_CLEAR));
		send_item(drain_item('1));
		for (int a = ACT_DRAIN + 1; a < 2 ** ACTION_W; a++) begin
			send_item(noisy_item(ACTION_W'(a)));
		end
		send_item(write_item(REG_W'(9), 8'h77, CLASS_NOTE));
		send_item(noisy_item(ACT_FLUSH));
		send_item(drain_item(SLOT_W'(FRAME_BUDGET)));
		wait_all_results();
	endtask

	task automatic test_queue_full();
		send_item(noisy_item(ACT_FLUSH));
		repeat (ENTRY_SLOTS + 3) send_item(random_write());
		repeat (3) send_item(drain_item(SLOT_W'(FRAME_BUDGET)));
		wait_all_results();
	endtask

	task automatic test_output_hold_off();
		hold_asked++;
		repeat (6) send_item(random_write());
		send_item(drain_item(SLOT_W'(FRAME_BUDGET)));
		repeat (5) send_item(random_write());
		send_item(random_drain());
		wait_all_results();
	endtask

	task automatic test_random_mix(input int unsigned item_goal, input int unsigned send_pct,
			input int unsigned recv_pct);
		int unsigned sent;
		int unsigned roll;
		int unsigned burst;
		sender_idle_pct = send_pct;
		receiver_idle_pct = recv_pct;
		sent = 0;
		while (sent < item_goal) begin
			roll = $urandom_range(99);
			if (roll < 8) begin
				burst = $urandom_range(36, 12);
				repeat (burst) send_item(random_write());
				sent += burst;
			end else begin
				if (roll < 55)
					send_item(random_write());
				else if (roll < 77)
					send_item(random_drain());
				else if (roll < 85)
					send_item(noisy_item(ACT_REMOVE));
				else if (roll < 91)
					send_item(noisy_item(ACT_MUSIC_CLEAR));
				else if (roll < 95)
					send_item(noisy_item(ACT_FLUSH));
				else
					send_item(noisy_item(ACTION_W'($urandom_range(2 ** ACTION_W - 1, ACT_DRAIN + 1))));
				sent++;
			end
		end
		wait_all_results();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idle_pct = 25;
		receiver_idle_pct = 47;
		test_directed_cases();
		test_queue_full();
		test_output_hold_off();
		test_random_mix(85, 25, 47);
		test_random_mix(85, 47, 25);
		test_random_mix(80, 0, 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && due_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

[class_ordered_write_queue_unit.f]
src/cwq_pkg.sv
src/cwq_ram.sv
src/cwq_ctrl.sv
src/cwq_dp.sv
src/class_ordered_write_queue_unit.sv
verif/testbench.sv
